// ----- src/button_press_classifier_assert.svh -----
// Assertion macros for the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("bpc assertion failed");

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("bpc assertion failed");

`endif

// ----- src/bpc_pkg.sv -----
// Package: types, register indexes and reset values for the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int TIME_WIDTH_DEF = 16;
  localparam int SETTLE_W       = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int THRESH_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN = CFG_IDX_W'(3);

  localparam logic [SETTLE_W-1:0] DEBOUNCE_RST  = SETTLE_W'(20);
  localparam logic [THRESH_W-1:0] HOLD_RST      = THRESH_W'(2000);
  localparam logic [THRESH_W-1:0] LONG_HOLD_RST = THRESH_W'(10000);
  localparam logic [THRESH_W-1:0] CLICK_MIN_RST = THRESH_W'(100);

  typedef enum logic [1:0] {
    PH_IDLE           = 2'd0,
    PH_PRESS_SETTLE   = 2'd1,
    PH_PRESSED        = 2'd2,
    PH_RELEASE_SETTLE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2,
    EV_LONG  = 2'd3
  } ev_t;

  typedef struct packed {
    phase_t                phase;
    logic                  prev_level;
    logic [SETTLE_W-1:0]   settle_count;
    logic                  hold_fired;
    logic                  long_fired;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- src/button_press_classifier.sv -----
// Top level of the button press classifier: state registers, config and result buffer.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  input     | in_valid / in_stall    | button_down (1 bit level per tick)
//  result    | out_valid / out_stall  | event_res (2 bit event code)
//  config    | cfg_wr_en              | cfg_index, cfg_data
//
// Each input transaction is one tick; on acceptance its event is registered into the
// output, or into the skid if the output is held. Sustained rate is one tick per cycle
// while in_stall is low: the whole update is one pass of bpc_step. A result waiting on
// out_stall parks in a one-entry skid; in_stall rises only when that skid is full, so
// input keeps flowing while it is empty. Synchronous active-high rst returns to idle,
// clears the timers and loads the default thresholds; no clearing pass is needed.
`default_nettype none
module button_press_classifier import bpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  button_down,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            event_res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [SETTLE_W-1:0]   debounce_ticks;
  logic [THRESH_W-1:0]   hold_ticks;
  logic [THRESH_W-1:0]   long_hold_ticks;
  logic [THRESH_W-1:0]   click_min_ticks;

  // Classifier state
  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [TIME_WIDTH-1:0] press_elapsed;
  logic [TIME_WIDTH-1:0] press_elapsed_next;
  logic [TIME_WIDTH-1:0] elapsed_at_edge;
  logic [TIME_WIDTH-1:0] elapsed_at_edge_next;
  ev_t                   step_ev;

  // Result buffer
  logic                  skid_valid;
  logic [1:0]            skid_event;
  logic                  in_acc;
  logic                  out_take;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks  <= DEBOUNCE_RST;
      hold_ticks      <= HOLD_RST;
      long_hold_ticks <= LONG_HOLD_RST;
      click_min_ticks <= CLICK_MIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_ticks  <= cfg_data[SETTLE_W-1:0];
        CFG_HOLD:      hold_ticks      <= cfg_data[THRESH_W-1:0];
        CFG_LONG_HOLD: long_hold_ticks <= cfg_data[THRESH_W-1:0];
        CFG_CLICK_MIN: click_min_ticks <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  bpc_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .ctrl                 (ctrl),
    .press_elapsed        (press_elapsed),
    .elapsed_at_edge      (elapsed_at_edge),
    .level                (button_down),
    .debounce_ticks       (debounce_ticks),
    .hold_ticks           (hold_ticks),
    .long_hold_ticks      (long_hold_ticks),
    .click_min_ticks      (click_min_ticks),
    .ctrl_next            (ctrl_next),
    .press_elapsed_next   (press_elapsed_next),
    .elapsed_at_edge_next (elapsed_at_edge_next),
    .ev                   (step_ev)
  );

  // Advance the classifier state once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl            <= '{phase: PH_IDLE, default: '0};
      press_elapsed   <= '0;
      elapsed_at_edge <= '0;
    end else if (in_acc) begin
      ctrl            <= ctrl_next;
      press_elapsed   <= press_elapsed_next;
      elapsed_at_edge <= elapsed_at_edge_next;
    end
  end

  // Output register plus skid: a fresh event goes straight to the output when
  // it is free or being taken, otherwise it parks in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload side of the buffer; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) event_res <= skid_event;
    end else if (in_acc) begin
      if (!out_valid || out_take) begin
        event_res <= step_ev;
      end else begin
        skid_event <= step_ev;
      end
    end
  end

  `include "button_press_classifier_assert.svh"

  // A parked result always sits behind a valid output.
  `BPC_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // After an accepted tick, out_valid is always high the next cycle.
  `BPC_ASSERT_NEXT(a_acc_gives_out, clk, rst, in_acc, out_valid)
  // A parked result is not lost while the output is stalled.
  `BPC_ASSERT_NEXT(a_skid_held, clk, rst, skid_valid && !out_take, skid_valid)
  // Long hold is only reported after hold within the same press.
  `BPC_ASSERT_NOW(a_long_after_hold, clk, rst, in_acc && (step_ev == EV_LONG),
                  ctrl.hold_fired)
  // Reporting hold marks it as fired for the rest of the press.
  `BPC_ASSERT_NEXT(a_hold_marked, clk, rst, in_acc && (step_ev == EV_HOLD),
                   ctrl.hold_fired)

endmodule
`default_nettype wire

// ----- src/bpc_step.sv -----
// Next-state and event logic for one millisecond tick of the classifier.
`default_nettype none
module bpc_step import bpc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  ctrl_t                 ctrl,
  input  logic [TIME_WIDTH-1:0] press_elapsed,
  input  logic [TIME_WIDTH-1:0] elapsed_at_edge,
  input  logic                  level,
  input  logic [SETTLE_W-1:0]   debounce_ticks,
  input  logic [THRESH_W-1:0]   hold_ticks,
  input  logic [THRESH_W-1:0]   long_hold_ticks,
  input  logic [THRESH_W-1:0]   click_min_ticks,
  output ctrl_t                 ctrl_next,
  output logic [TIME_WIDTH-1:0] press_elapsed_next,
  output logic [TIME_WIDTH-1:0] elapsed_at_edge_next,
  output ev_t                   ev
);

  localparam int CMP_W = (TIME_WIDTH > THRESH_W) ? TIME_WIDTH : THRESH_W;

  logic                  edge_seen;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [SETTLE_W-1:0]   settle_inc;
  logic                  settle_done;
  logic                  hold_hit;
  logic                  long_hit;
  logic                  click_ok;

  assign edge_seen   = level != ctrl.prev_level;
  assign elapsed_inc = (&press_elapsed) ? press_elapsed : press_elapsed + 1'b1;
  assign settle_inc  = (&ctrl.settle_count) ? ctrl.settle_count
                                            : ctrl.settle_count + 1'b1;
  // A zero debounce setting behaves as one, since settle_inc is never zero.
  assign settle_done = settle_inc >= debounce_ticks;
  assign hold_hit    = CMP_W'(elapsed_inc) >= CMP_W'(hold_ticks);
  assign long_hit    = CMP_W'(elapsed_inc) >= CMP_W'(long_hold_ticks);
  assign click_ok    = !ctrl.hold_fired &&
                       (CMP_W'(elapsed_at_edge) >= CMP_W'(click_min_ticks));

  always_comb begin
    ctrl_next            = ctrl;
    ctrl_next.prev_level = level;
    press_elapsed_next   = press_elapsed;
    elapsed_at_edge_next = elapsed_at_edge;
    ev                   = EV_NONE;
    unique case (ctrl.phase)
      PH_IDLE: begin
        if (edge_seen) begin
          ctrl_next.phase        = PH_PRESS_SETTLE;
          ctrl_next.settle_count = '0;
        end
      end
      PH_PRESS_SETTLE: begin
        ctrl_next.settle_count = settle_inc;
        if (settle_done) begin
          if (level) begin
            ctrl_next.phase      = PH_PRESSED;
            ctrl_next.hold_fired = 1'b0;
            ctrl_next.long_fired = 1'b0;
            press_elapsed_next   = '0;
          end else begin
            ctrl_next.phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        press_elapsed_next = elapsed_inc;
        if (edge_seen) begin
          elapsed_at_edge_next   = elapsed_inc;
          ctrl_next.settle_count = '0;
          ctrl_next.phase        = PH_RELEASE_SETTLE;
        end else if (!ctrl.hold_fired) begin
          if (hold_hit) begin
            ctrl_next.hold_fired = 1'b1;
            ev                   = EV_HOLD;
          end
        end else if (!ctrl.long_fired) begin
          if (long_hit) begin
            ctrl_next.long_fired = 1'b1;
            ev                   = EV_LONG;
          end
        end
      end
      PH_RELEASE_SETTLE: begin
        press_elapsed_next     = elapsed_inc;
        ctrl_next.settle_count = settle_inc;
        if (settle_done) begin
          if (level) begin
            ctrl_next.phase = PH_PRESSED;
          end else begin
            if (click_ok) ev = EV_CLICK;
            ctrl_next.phase = PH_IDLE;
          end
        end
      end
      default: begin
        ctrl_next.phase = PH_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
